// ===== rtl/core/pfba_pkg.sv =====
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared types, constants and helpers for the page frame bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfba_pkg;

  // Default sizing
  localparam int unsigned NumPagesDef      = 65536;
  localparam int unsigned ReservedPagesDef = 8192;

  // Bitmap memory word and field widths
  localparam int unsigned WordW      = 64;
  localparam int unsigned CountW     = 17;
  localparam int unsigned AddrW      = 28;
  localparam int unsigned BytesW     = 29;
  localparam int unsigned FrameShift = 12;
  localparam int unsigned InDataW    = 48;
  localparam int unsigned OutDataW   = 64;

  // Request kinds
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_RESP
  } pfba_state_e;

  typedef logic [WordW-1:0] pfba_word_t;

  // Mask with the lowest n bits set, n in 0..64
  function automatic pfba_word_t low_mask(input logic [6:0] n);
    pfba_word_t m;
    if (n >= 7'd64) begin
      m = '1;
    end else begin
      m = (pfba_word_t'(1) << n[5:0]) - pfba_word_t'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/page_frame_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// First-fit contiguous page allocator over a used-bit map held in a 64-bit
// wide synchronous memory, plus a saturating free page count.
// ----------------------------------------------------------------------------
// Allocate scans the bitmap one memory word per cycle, then marks the
//   words of the found run one per cycle.
// Free clears the bitmap words of its run one per cycle.
// One item is worked on at a time; the result register lets the next item in.
// Reset: after rst_ni rises, a clearing pass writes ceil(NUM_PAGES/64) words
//   (first RSVD_FRAMES frames used) before the first item is accepted.
`default_nettype none

module page_frame_bitmap_allocator #(
  parameter int unsigned NUM_PAGES   = pfba_pkg::NumPagesDef,
  parameter int unsigned RSVD_FRAMES = pfba_pkg::ReservedPagesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Request item
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // [16:0] page_count, [44:17] phys_addr, [47:45] zero
  input  wire logic [pfba_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] operation
  input  wire logic [0:0]                    s_axis_tuser,
  // Result item
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [27:0] alloc_addr, [56:28] free_bytes, [63:57] zero
  output      logic [pfba_pkg::OutDataW-1:0] m_axis_tdata,
  // [0] alloc_ok
  output      logic [0:0]                    m_axis_tuser
);

  localparam int unsigned WW      = pfba_pkg::WordW;
  localparam int unsigned WORDS   = (NUM_PAGES + WW - 1) / WW;
  localparam int unsigned WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CNT_W   = $clog2(NUM_PAGES + 1);
  localparam int unsigned EXT_W   = (CNT_W > 18) ? CNT_W : 18;
  localparam int unsigned R_EFF   = (RSVD_FRAMES > NUM_PAGES) ? NUM_PAGES : RSVD_FRAMES;
  localparam int unsigned R_FULLW = R_EFF / WW;
  localparam int unsigned R_REM   = R_EFF % WW;
  localparam int unsigned N_REM   = NUM_PAGES % WW;
  localparam int unsigned CW      = pfba_pkg::CountW;

  localparam logic [WORD_AW-1:0] LAST_W  = WORD_AW'(WORDS - 1);
  localparam logic [EXT_W-1:0]   NP_X    = EXT_W'(NUM_PAGES);
  localparam logic [CNT_W-1:0]   NP_C    = CNT_W'(NUM_PAGES);
  localparam logic [WORD_AW:0]   RFW_X   = (WORD_AW + 1)'(R_FULLW);
  localparam pfba_pkg::pfba_word_t PAD   =
      (N_REM == 0) ? '0 : ~pfba_pkg::low_mask(7'(N_REM));
  localparam pfba_pkg::pfba_word_t R_PART = pfba_pkg::low_mask(7'(R_REM));

  // Bitmap memory
  pfba_pkg::pfba_word_t mem_q [WORDS];
  pfba_pkg::pfba_word_t rdata_q;
  logic                 mem_we, mem_re;
  logic [WORD_AW-1:0]   mem_wa, mem_ra;
  pfba_pkg::pfba_word_t mem_wd;

  // Control state
  pfba_pkg::pfba_state_e state_q, state_d;
  logic [WORD_AW-1:0]    init_ptr_q, init_ptr_d;
  logic [CNT_W-1:0]      free_cnt_q, free_cnt_d;
  logic                  sc_issue_q, sc_issue_d, sc_vld_q;
  logic                  mk_issue_q, mk_issue_d, mk_vld_q;
  logic                  out_vld_q, out_vld_d;

  // Work registers
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         run_q, run_d;
  logic [WORD_AW-1:0]    sc_ptr_q, sc_ptr_d, sc_w_q;
  logic [WORD_AW-1:0]    mk_ptr_q, mk_ptr_d, mk_wa_q;
  logic [EXT_W-1:0]      lo_q, lo_d, e_q, e_d;
  logic                  set_q, set_d, ok_q, ok_d;
  logic [pfba_pkg::AddrW-1:0]  out_addr_q, out_addr_d;
  logic [pfba_pkg::BytesW-1:0] out_fb_q, out_fb_d;
  logic                  out_ok_q, out_ok_d;

  // Scan evaluation of the word just read
  pfba_pkg::pfba_word_t  d_eff, f_bits;
  logic [WW-1:0]         hit_vec;
  logic                  hit_any, word_free;
  logic [5:0]            hit_idx, hi_used;

  // Marking helpers
  logic [WORD_AW-1:0]    lo_w, e_w;
  pfba_pkg::pfba_word_t  mk_mask;

  // Request decode
  logic                  in_acc;
  logic                  in_op;
  logic [CW-1:0]         in_cnt;
  logic [EXT_W-1:0]      in_lo, in_end, in_sum;
  logic [40:0]           fb_wide, addr_wide;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign in_op  = s_axis_tuser[0];
  assign in_cnt = s_axis_tdata[CW-1:0];
  assign in_lo  = EXT_W'(s_axis_tdata[CW+pfba_pkg::AddrW-1:CW+pfba_pkg::FrameShift]);
  assign in_end = in_lo + EXT_W'(in_cnt) - EXT_W'(1);
  assign in_sum = EXT_W'(free_cnt_q) + EXT_W'(in_cnt);

  assign s_axis_tready = (state_q == pfba_pkg::ST_IDLE);

  // Find the first run end within the current word
  always_comb begin
    pfba_pkg::pfba_word_t lm, wm;
    logic [CW:0]          reach;
    logic                 full_j;
    d_eff   = rdata_q | ((sc_w_q == LAST_W) ? PAD : '0);
    f_bits  = ~d_eff;
    hit_vec = '0;
    for (int j = 0; j < WW; j++) begin
      lm     = pfba_pkg::low_mask(7'(j + 1));
      full_j = &(f_bits | ~lm);
      reach  = {1'b0, run_q} + (CW + 1)'(j + 1);
      wm     = lm & ~pfba_pkg::low_mask(7'(j + 1) - cnt_q[6:0]);
      hit_vec[j] = (full_j && (reach >= {1'b0, cnt_q})) ||
                   ((cnt_q <= CW'(j + 1)) && (&(f_bits | ~wm)));
    end
    hit_any = |hit_vec;
    hit_idx = '0;
    for (int j = WW - 1; j >= 0; j--) begin
      if (hit_vec[j]) hit_idx = 6'(j);
    end
    hi_used = '0;
    for (int j = 0; j < WW; j++) begin
      if (d_eff[j]) hi_used = 6'(j);
    end
    word_free = ~|d_eff;
  end

  // Mask of frames in [lo, e] within the word being written back
  assign lo_w = lo_q[WORD_AW+5:6];
  assign e_w  = e_q[WORD_AW+5:6];
  always_comb begin
    mk_mask = '1;
    if (mk_wa_q == lo_w) mk_mask = mk_mask & ('1 << lo_q[5:0]);
    if (mk_wa_q == e_w)  mk_mask = mk_mask & ('1 >> (~e_q[5:0]));
  end

  // Next state and memory port control
  always_comb begin
    logic [EXT_W-1:0] end_f;
    logic [EXT_W-1:0] lo_hit;
    state_d    = state_q;
    init_ptr_d = init_ptr_q;
    free_cnt_d = free_cnt_q;
    sc_issue_d = sc_issue_q;
    mk_issue_d = mk_issue_q;
    sc_ptr_d   = sc_ptr_q;
    mk_ptr_d   = mk_ptr_q;
    cnt_d      = cnt_q;
    run_d      = run_q;
    lo_d       = lo_q;
    e_d        = e_q;
    set_d      = set_q;
    ok_d       = ok_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_addr_d = out_addr_q;
    out_fb_d   = out_fb_q;
    out_ok_d   = out_ok_q;
    mem_we     = 1'b0;
    mem_wa     = init_ptr_q;
    mem_wd     = '0;
    mem_re     = 1'b0;
    mem_ra     = sc_ptr_q;
    end_f      = EXT_W'({sc_w_q, hit_idx});
    lo_hit     = end_f + EXT_W'(1) - EXT_W'(cnt_q);
    fb_wide    = 41'(free_cnt_q) << pfba_pkg::FrameShift;
    addr_wide  = 41'(lo_q) << pfba_pkg::FrameShift;

    case (state_q)
      // Write the reset pattern one word per cycle
      pfba_pkg::ST_INIT: begin
        mem_we = 1'b1;
        mem_wa = init_ptr_q;
        if ({1'b0, init_ptr_q} < RFW_X) begin
          mem_wd = '1;
        end else if ({1'b0, init_ptr_q} == RFW_X) begin
          mem_wd = R_PART;
        end else begin
          mem_wd = '0;
        end
        init_ptr_d = init_ptr_q + WORD_AW'(1);
        if (init_ptr_q == LAST_W) state_d = pfba_pkg::ST_IDLE;
      end

      pfba_pkg::ST_IDLE: begin
        if (in_acc) begin
          cnt_d = in_cnt;
          ok_d  = 1'b0;
          if (in_op == pfba_pkg::OpAlloc) begin
            if (in_cnt == '0) begin
              state_d = pfba_pkg::ST_RESP;
            end else begin
              state_d    = pfba_pkg::ST_SCAN;
              run_d      = '0;
              sc_ptr_d   = '0;
              sc_issue_d = 1'b1;
            end
          end else begin
            // Count is added in full, saturating at the table size
            free_cnt_d = (in_sum > NP_X) ? NP_C : CNT_W'(in_sum);
            lo_d       = in_lo;
            e_d        = (in_end >= NP_X) ? (NP_X - EXT_W'(1)) : in_end;
            set_d      = 1'b0;
            if ((in_cnt != '0) && (in_lo < NP_X)) begin
              state_d    = pfba_pkg::ST_MARK;
              mk_ptr_d   = in_lo[WORD_AW+5:6];
              mk_issue_d = 1'b1;
            end else begin
              state_d = pfba_pkg::ST_RESP;
            end
          end
        end
      end

      // Stream words in and track the free run crossing word borders
      pfba_pkg::ST_SCAN: begin
        mem_re = sc_issue_q;
        mem_ra = sc_ptr_q;
        if (sc_issue_q) begin
          sc_ptr_d = sc_ptr_q + WORD_AW'(1);
          if (sc_ptr_q == LAST_W) sc_issue_d = 1'b0;
        end
        if (sc_vld_q) begin
          if (hit_any) begin
            state_d    = pfba_pkg::ST_MARK;
            sc_issue_d = 1'b0;
            lo_d       = lo_hit;
            e_d        = end_f;
            set_d      = 1'b1;
            ok_d       = 1'b1;
            mk_ptr_d   = lo_hit[WORD_AW+5:6];
            mk_issue_d = 1'b1;
            free_cnt_d = (EXT_W'(free_cnt_q) >= EXT_W'(cnt_q)) ?
                         CNT_W'(EXT_W'(free_cnt_q) - EXT_W'(cnt_q)) : '0;
          end else if (sc_w_q == LAST_W) begin
            state_d = pfba_pkg::ST_RESP;
          end else if (word_free) begin
            run_d = run_q + CW'(WW);
          end else begin
            run_d = CW'(6'd63 - hi_used);
          end
        end
      end

      // Read, modify and write back each word of the run
      pfba_pkg::ST_MARK: begin
        mem_re = mk_issue_q;
        mem_ra = mk_ptr_q;
        if (mk_issue_q) begin
          mk_ptr_d = mk_ptr_q + WORD_AW'(1);
          if (mk_ptr_q == e_w) mk_issue_d = 1'b0;
        end
        if (mk_vld_q) begin
          mem_we = 1'b1;
          mem_wa = mk_wa_q;
          mem_wd = set_q ? (rdata_q | mk_mask) : (rdata_q & ~mk_mask);
          if (mk_wa_q == e_w) state_d = pfba_pkg::ST_RESP;
        end
      end

      // Hand the result to the output register once it is free
      pfba_pkg::ST_RESP: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_ok_d   = ok_q;
          out_addr_d = ok_q ? addr_wide[pfba_pkg::AddrW-1:0] : '0;
          out_fb_d   = fb_wide[pfba_pkg::BytesW-1:0];
          state_d    = pfba_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = pfba_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pfba_pkg::ST_INIT;
      init_ptr_q <= '0;
      free_cnt_q <= CNT_W'(NUM_PAGES - R_EFF);
      sc_issue_q <= 1'b0;
      sc_vld_q   <= 1'b0;
      mk_issue_q <= 1'b0;
      mk_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      init_ptr_q <= init_ptr_d;
      free_cnt_q <= free_cnt_d;
      sc_issue_q <= sc_issue_d;
      sc_vld_q   <= (state_q == pfba_pkg::ST_SCAN) && sc_issue_q;
      mk_issue_q <= mk_issue_d;
      mk_vld_q   <= (state_q == pfba_pkg::ST_MARK) && mk_issue_q;
      out_vld_q  <= out_vld_d;
    end
  end

  // Work and result registers
  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    run_q      <= run_d;
    sc_ptr_q   <= sc_ptr_d;
    sc_w_q     <= sc_ptr_q;
    mk_ptr_q   <= mk_ptr_d;
    mk_wa_q    <= mk_ptr_q;
    lo_q       <= lo_d;
    e_q        <= e_d;
    set_q      <= set_d;
    ok_q       <= ok_d;
    out_addr_q <= out_addr_d;
    out_fb_q   <= out_fb_d;
    out_ok_q   <= out_ok_d;
  end

  // Bitmap memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (mem_re) rdata_q <= mem_q[mem_ra];
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = pfba_pkg::OutDataW'({out_fb_q, out_addr_q});
  assign m_axis_tuser  = out_ok_q;

  // Checks
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == pfba_pkg::ST_INIT || state_q == pfba_pkg::ST_MARK))
    else $error("bitmap written outside init or mark");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= NP_C)
    else $error("free count above table size");

  a_mk_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mk_vld_q |-> (state_q == pfba_pkg::ST_MARK))
    else $error("write-back data outside mark phase");

  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != pfba_pkg::ST_IDLE))
    else $error("accepted item did not start work");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and free requests into page_frame_bitmap_allocator and
// checks every result item against a first-fit bitmap predictor kept here.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned Pages       = pfba_pkg::NumPagesDef;
  localparam int unsigned Reserved    = pfba_pkg::ReservedPagesDef;
  localparam int unsigned MapWords    = (Pages + pfba_pkg::WordW - 1) / pfba_pkg::WordW;
  localparam int unsigned DrainCycles = 2 * MapWords + 64;
  localparam int unsigned MaxShown    = 10;
  localparam int unsigned PadW        = pfba_pkg::InDataW - pfba_pkg::AddrW - pfba_pkg::CountW;

  // One predicted result item
  typedef struct packed {
    logic [pfba_pkg::AddrW-1:0]  addr;
    logic                        ok;
    logic [pfba_pkg::BytesW-1:0] free_bytes;
  } grant_t;

  // A run handed out by the block and not yet returned
  typedef struct {
    int unsigned first;
    int unsigned count;
  } page_run_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [pfba_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic [0:0]                    s_axis_tuser  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [pfba_pkg::OutDataW-1:0] m_axis_tdata;
  logic [0:0]                    m_axis_tuser;

  // Predictor state
  bit          frame_used[Pages];
  int unsigned free_pages;
  grant_t      pending_grants[$];
  page_run_t   live_runs[$];
  page_run_t   last_freed;
  bit          have_freed = 1'b0;

  int unsigned mismatches = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;
  int unsigned hold_len   = 0;
  int unsigned hold_token = 0;
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;
  int unsigned rx_wait    = 0;

  page_frame_bitmap_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Mark the reserved frames used, the rest free
  function automatic void reset_frame_map();
    int unsigned taken;
    taken = (Reserved < Pages) ? Reserved : Pages;
    for (int unsigned f = 0; f < Pages; f++) begin
      frame_used[f] = (f < taken);
    end
    free_pages = Pages - taken;
  endfunction

  // Apply one request to the frame map and return the result it yields
  function automatic grant_t compute_grant(input logic op,
                                           input logic [pfba_pkg::CountW-1:0] count,
                                           input logic [pfba_pkg::AddrW-1:0] paddr);
    grant_t          g;
    int unsigned     n;
    int unsigned     run;
    int unsigned     start;
    int unsigned     first;
    bit              found;
    longint unsigned sum;
    g     = '0;
    n     = count;
    run   = 0;
    start = 0;
    found = 1'b0;
    if (op == pfba_pkg::OpAlloc) begin
      if (n != 0) begin
        // First fit: lowest run of n free frames
        for (int unsigned f = 0; f < Pages && !found; f++) begin
          if (frame_used[f]) begin
            run = 0;
          end else begin
            if (run == 0) start = f;
            run++;
            if (run == n) found = 1'b1;
          end
        end
        if (found) begin
          for (int unsigned i = 0; i < n; i++) frame_used[start + i] = 1'b1;
          free_pages = (free_pages >= n) ? free_pages - n : 0;
          g.addr     = pfba_pkg::AddrW'(start << pfba_pkg::FrameShift);
          g.ok       = 1'b1;
        end
      end
    end else begin
      // Clear what lies inside the table, credit the full count
      first = paddr >> pfba_pkg::FrameShift;
      for (int unsigned i = 0; i < n && first + i < Pages; i++) frame_used[first + i] = 1'b0;
      sum        = longint'(free_pages) + n;
      free_pages = (sum > Pages) ? Pages : int'(sum);
    end
    g.free_bytes = pfba_pkg::BytesW'(longint'(free_pages) << pfba_pkg::FrameShift);
    return g;
  endfunction

  // Idle length: mostly none or short, a few long
  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Allocation size: mostly small, rarely up to the whole table
  function automatic int unsigned alloc_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 90) return $urandom_range(9, 256);
    if (r < 97) return $urandom_range(257, 4096);
    return $urandom_range(0, Pages);
  endfunction

  // Offer one request item, predict its result once accepted
  task automatic send_request(input logic op, input int unsigned count,
                              input logic [pfba_pkg::AddrW-1:0] paddr, output grant_t g);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{PadW{1'b0}}, paddr, pfba_pkg::CountW'(count)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    g = compute_grant(op, pfba_pkg::CountW'(count), paddr);
    pending_grants.push_back(g);
    gap = tx_gaps_on ? gap_cycles() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Track a granted run so it can be returned later
  task automatic remember_run(input int unsigned count, input grant_t g);
    page_run_t r;
    if (g.ok) begin
      r.first = g.addr >> pfba_pkg::FrameShift;
      r.count = count;
      live_runs.push_back(r);
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MaxShown) $display("%0t: %s", $realtime, what);
  endtask

  // Drive result ready: long hold-offs on request, random stalls otherwise
  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen     <= hold_token;
      hold_left     <= hold_len;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait       <= rx_wait - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_gaps_on) rx_wait <= gap_cycles();
    end
  end

  // Compare each result item with the oldest prediction
  always @(posedge clk_i) begin : check_results
    grant_t want;
    grant_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.addr       = m_axis_tdata[pfba_pkg::AddrW-1:0];
      got.ok         = m_axis_tuser[0];
      got.free_bytes = m_axis_tdata[pfba_pkg::AddrW +: pfba_pkg::BytesW];
      if (pending_grants.size() == 0) begin
        note_mismatch($sformatf("result with no request waiting: addr %h ok %b free %h",
                                got.addr, got.ok, got.free_bytes));
      end else begin
        want = pending_grants.pop_front();
        if (got.addr !== want.addr || got.ok !== want.ok ||
            got.free_bytes !== want.free_bytes) begin
          note_mismatch($sformatf("expected addr %h ok %b free %h, got addr %h ok %b free %h",
                                  want.addr, want.ok, want.free_bytes,
                                  got.addr, got.ok, got.free_bytes));
        end
      end
    end
  end

  // Zero size, first fit past the reserved area, no run, exact fill, full map
  task automatic test_alloc_limits();
    grant_t g;
    send_request(pfba_pkg::OpAlloc, 0, '0, g);
    send_request(pfba_pkg::OpAlloc, 1, pfba_pkg::AddrW'('hFFFFFFF), g);
    send_request(pfba_pkg::OpAlloc, Pages, '0, g);
    send_request(pfba_pkg::OpAlloc, Pages - Reserved - 1, '0, g);
    send_request(pfba_pkg::OpAlloc, 1, '0, g);
  endtask

  // Whole-table free, run at frame 0, free past the table end, empty free,
  // double free that credits its count twice, then back to the layout after reset
  task automatic test_free_limits();
    grant_t g;
    send_request(pfba_pkg::OpFree, Pages, pfba_pkg::AddrW'('hFFF), g);
    send_request(pfba_pkg::OpAlloc, Pages, '0, g);
    send_request(pfba_pkg::OpFree, Pages, pfba_pkg::AddrW'('hFFFFFFF), g);
    send_request(pfba_pkg::OpAlloc, 2, '0, g);
    send_request(pfba_pkg::OpAlloc, 1, '0, g);
    send_request(pfba_pkg::OpFree, 0, pfba_pkg::AddrW'('h0123000), g);
    send_request(pfba_pkg::OpFree, 4, pfba_pkg::AddrW'(100 << pfba_pkg::FrameShift), g);
    send_request(pfba_pkg::OpFree, 4, pfba_pkg::AddrW'(100 << pfba_pkg::FrameShift), g);
    send_request(pfba_pkg::OpAlloc, 4, '0, g);
    send_request(pfba_pkg::OpFree, Pages, '0, g);
    send_request(pfba_pkg::OpAlloc, Reserved, '0, g);
  endtask

  // Hold off the result side while requests keep coming, so input stalls
  task automatic test_output_stall();
    grant_t      g;
    int unsigned count;
    hold_len   <= 600;
    hold_token <= hold_token + 1;
    tx_gaps_on <= 1'b0;
    for (int k = 0; k < 24; k++) begin
      count = $urandom_range(1, 8);
      send_request(pfba_pkg::OpAlloc, count, pfba_pkg::AddrW'($urandom), g);
      remember_run(count, g);
    end
  endtask

  // Mostly allocations and returns of granted runs, some noise
  task automatic test_random_traffic(input int unsigned items);
    grant_t      g;
    page_run_t   r;
    int unsigned pick;
    int unsigned count;
    int unsigned idx;
    for (int unsigned k = 0; k < items; k++) begin
      if (k % 120 == 0) begin
        tx_gaps_on <= ($urandom_range(0, 2) != 0);
        rx_gaps_on <= ($urandom_range(0, 2) != 0);
      end
      pick = $urandom_range(0, 99);
      if (free_pages < 2048 || live_runs.size() > 300) begin
        // Start over from the reset layout
        send_request(pfba_pkg::OpFree, Pages, '0, g);
        live_runs.delete();
        send_request(pfba_pkg::OpAlloc, Reserved, '0, g);
      end else if (pick < 45) begin
        count = alloc_size();
        send_request(pfba_pkg::OpAlloc, count, pfba_pkg::AddrW'($urandom), g);
        remember_run(count, g);
      end else if (pick < 80 && live_runs.size() != 0) begin
        idx = $urandom_range(0, live_runs.size() - 1);
        r   = live_runs[idx];
        live_runs.delete(idx);
        send_request(pfba_pkg::OpFree, r.count,
                     pfba_pkg::AddrW'(r.first << pfba_pkg::FrameShift) |
                     pfba_pkg::AddrW'($urandom_range(0, 4095)), g);
        last_freed = r;
        have_freed = 1'b1;
      end else if (pick < 86 && have_freed) begin
        send_request(pfba_pkg::OpFree, last_freed.count,
                     pfba_pkg::AddrW'(last_freed.first << pfba_pkg::FrameShift), g);
      end else if (pick < 90) begin
        send_request(pfba_pkg::OpAlloc, 0, pfba_pkg::AddrW'($urandom), g);
      end else begin
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, Pages) : $urandom_range(0, 64);
        send_request(pfba_pkg::OpFree, count, pfba_pkg::AddrW'($urandom), g);
      end
    end
  endtask

  initial begin
    reset_frame_map();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_alloc_limits();
    test_free_limits();
    test_output_stall();
    test_random_traffic(530);
    s_axis_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("page_frame_bitmap_allocator test passed");
    end else begin
      $display("page_frame_bitmap_allocator test failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #40_000_000;
    $display("page_frame_bitmap_allocator test failed");
    $finish;
  end

endmodule
